/* rtl/olir_pkg.sv */
// Shared constants and types for the ordered list block.
// No dependencies; the interfaces, the top level and the checker import this package.
`timescale 1ns / 1ps

package olir_pkg;

   localparam int DEPTH         = 16;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int DATA_W        = 32;
   localparam int POS_W         = 5;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;
   localparam int CMP_W         = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_DUMP   = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

endpackage

/* rtl/olir_ifs.sv */
// Valid/ready channel interfaces for the ordered list block: request and response.
// Depends on olir_pkg for field widths.
`timescale 1ns / 1ps

interface olir_req_if import olir_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, opcode, value, position, input ready);
   modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface olir_rsp_if import olir_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] element;
   logic [ENTRY_COUNT_W-1:0] entry_count;
   logic                     last_of_run;

   modport source (output valid, status, element, entry_count, last_of_run, input ready);
   modport sink   (input valid, status, element, entry_count, last_of_run, output ready);
endinterface

/* rtl/olir_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module olir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ordered_list_insert_remove.sv */
// Ordered list of up to DEPTH signed 32-bit entries held in one RAM, with insert at a
// position, remove of the first equal value and an in-order dump. One request item is
// worked on at a time; all entry moves go through the single registered RAM read port,
// with a read state and a second state that writes, compares or outputs the entry for
// each entry moved or scanned. The block goes back to idle before the next request item
// is taken, and it waits while the response slot is held by a stalled item. A dump gives
// one response item per entry with last_of_run set on the final one; every other
// request gives one item.
`timescale 1ns / 1ps

module ordered_list_insert_remove
   import olir_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   olir_req_if.sink   req,
   olir_rsp_if.source rsp
);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_INS_RD  = 10'b00_0000_0010,
      S_INS_WR  = 10'b00_0000_0100,
      S_RM_RD   = 10'b00_0000_1000,
      S_RM_CMP  = 10'b00_0001_0000,
      S_SH_RD   = 10'b00_0010_0000,
      S_SH_WR   = 10'b00_0100_0000,
      S_DMP_RD  = 10'b00_1000_0000,
      S_DMP_OUT = 10'b01_0000_0000,
      S_RESP    = 10'b10_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   status_type          st_ff, st_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]        rsp_element_ff, rsp_element_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   logic              slot_free;
   logic [CNT_W-1:0]  idx_next;
   logic [CNT_W-1:0]  idx_prev;

   olir_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign idx_next  = CNT_W'(idx_ff + 1'b1);
   assign idx_prev  = CNT_W'(idx_ff - 1'b1);
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      value_in       = value_ff;
      st_in          = st_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IDX_W-1:0];
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               value_in = req.value;
               idx_in   = '0;
               unique case (req.opcode)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        st_in    = ST_FULL;
                        state_in = S_RESP;
                     end else if (CMP_W'(req.position) > CMP_W'(count_ff)) begin
                        st_in    = ST_BADPOS;
                        state_in = S_RESP;
                     end else begin
                        pos_in   = IDX_W'(req.position);
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_REMOVE: begin
                     state_in = S_RM_RD;
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        st_in    = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DMP_RD;
                     end
                  end
                  default: begin
                     st_in    = ST_OK;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == CNT_W'(pos_ff)) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = value_ff;
               count_in = CNT_W'(count_ff + 1'b1);
               st_in    = ST_OK;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_prev[IDX_W-1:0];
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_prev;
            state_in = S_INS_RD;
         end
         S_RM_RD: begin
            if (idx_ff == count_ff) begin
               st_in    = ST_NOTFOUND;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_RM_CMP;
            end
         end
         S_RM_CMP: begin
            if (rd_data == value_ff) begin
               state_in = S_SH_RD;
            end else begin
               idx_in   = idx_next;
               state_in = S_RM_RD;
            end
         end
         S_SH_RD: begin
            if (idx_next == count_ff) begin
               count_in = CNT_W'(count_ff - 1'b1);
               st_in    = ST_OK;
               state_in = S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_next[IDX_W-1:0];
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_next;
            state_in = S_SH_RD;
         end
         S_DMP_RD: begin
            rd_en    = 1'b1;
            state_in = S_DMP_OUT;
         end
         S_DMP_OUT: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_element_in = rd_data;
               rsp_count_in   = ENTRY_COUNT_W'(count_ff);
               rsp_last_in    = (idx_next == count_ff);
               if (idx_next == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_DMP_RD;
               end
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = st_ff;
               rsp_element_in = '0;
               rsp_count_in   = ENTRY_COUNT_W'(count_ff);
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      value_ff       <= value_in;
      st_ff          <= st_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.element     = rsp_element_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign rsp.last_of_run = rsp_last_ff;

endmodule

/* rtl/olir_checker.sv */
// Port-level checks for the ordered list block, attached by bind to the top level.
// Depends on olir_pkg and on the top level ordered_list_insert_remove.
`timescale 1ns / 1ps

module olir_checker
   import olir_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [DATA_W-1:0]        rsp_element,
   input logic [ENTRY_COUNT_W-1:0] rsp_entry_count,
   input logic                     rsp_last_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_element) && $stable(rsp_entry_count) && $stable(rsp_last_of_run))
      else $error("response item changed while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_entry_count) <= DEPTH)
      else $error("entry count beyond capacity");

   a_error_no_element: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_element == '0 && rsp_last_of_run)
      else $error("error item carries an element or is not last");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with entries held");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> int'(rsp_entry_count) == DEPTH)
      else $error("full status with room left");

endmodule

bind ordered_list_insert_remove olir_checker u_olir_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_element     (rsp.element),
   .rsp_entry_count (rsp.entry_count),
   .rsp_last_of_run (rsp.last_of_run)
);
